// File: design/gwdp_pkg.sv
package gwdp_pkg;

  localparam int unsigned LANES = 4;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COLUMN_W = 16;
  localparam int unsigned DOT_W = 41;
  localparam int unsigned ACC_W = 48;
  localparam int unsigned WEIGHT_W = 15;
  localparam int unsigned PROD_W = SAMPLE_W + WEIGHT_W;
  localparam int unsigned ROWLEN_W = 13;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned DEF_MAX_ROW_LENGTH = 4096;

  localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam logic [31:0] LAYER_MUL = 32'h85ebca6b;
  localparam logic [31:0] COLUMN_MUL = 32'hc2b2ae35;
  localparam logic [7:0] DIVISOR = 8'd81;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(40);
  // ceil(2^30 / 81), exact for dividends below 2^23
  localparam logic [23:0] RECIP81 = 24'd13256072;
  localparam int unsigned RECIP_SHIFT = 30;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SEED = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAYER = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 8'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [COLUMN_W-1:0]        column;
    logic                       column_start;
  } item_t;

  typedef struct packed {
    logic [63:0]         root_seed;
    logic [15:0]         layer_number;
    logic [ROWLEN_W-1:0] row_length;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX,
    ST_MUL,
    ST_MULX,
    ST_DRAW,
    ST_WT,
    ST_MAC,
    ST_ACC,
    ST_DIVI,
    ST_DIV,
    ST_OUT
  } state_e;

  // exact weight times 81 from one draw
  function automatic logic signed [WEIGHT_W-1:0] weight81(input logic [63:0] e);
    logic [9:0]  m;
    logic [9:0]  r;
    logic [13:0] mag;
    logic [13:0] base;
    begin
      m = e[13:4];
      if (m >= 10'd972) begin
        r = m - 10'd972;
      end else if (m >= 10'd729) begin
        r = m - 10'd729;
      end else if (m >= 10'd486) begin
        r = m - 10'd486;
      end else if (m >= 10'd243) begin
        r = m - 10'd243;
      end else begin
        r = m;
      end
      base = 14'd81 + 14'(r);
      case (e[3:2])
        2'd0: mag = base;
        2'd1: mag = 14'(base * 14'd3);
        2'd2: mag = 14'(base * 14'd9);
        2'd3: mag = 14'(base * 14'd27);
        default: mag = base;
      endcase
      case (e[1:0])
        2'd1: weight81 = $signed({1'b0, mag});
        2'd2: weight81 = -$signed({1'b0, mag});
        default: weight81 = '0;
      endcase
    end
  endfunction

endpackage

// File: design/gwdp_front.sv
module gwdp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gwdp_pkg::item_t item_i,
  output logic            full_o,
  output logic            item_valid_o,
  output gwdp_pkg::item_t item_o,
  input  logic            item_pop_i
);
  import gwdp_pkg::*;

  item_t       slot_q [2];
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push, do_pop;

  assign full_o       = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // column starts pass through with the word, the back end reseeds on them
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

// File: design/gwdp_back.sv
module gwdp_back #(
  parameter int unsigned MAX_ROW_LENGTH = gwdp_pkg::DEF_MAX_ROW_LENGTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gwdp_pkg::cfg_t                    cfg_i,
  input  logic                              item_valid_i,
  input  gwdp_pkg::item_t                   item_i,
  output logic                              item_pop_o,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [gwdp_pkg::DOT_W-1:0] dot_o
);
  import gwdp_pkg::*;

  localparam int unsigned KW = $clog2(MAX_ROW_LENGTH + 1);
  localparam int unsigned LW = (KW > ROWLEN_W) ? KW : ROWLEN_W;
  localparam logic [LW-1:0] KMAX = LW'(MAX_ROW_LENGTH);

  state_e state_q, state_d;

  logic [63:0] lane_a_q [LANES];
  logic [63:0] lane_b_q [LANES];
  logic [63:0] buf_q [LANES];
  logic [63:0] nb_w [LANES];
  logic [63:0] draw_w [LANES];

  logic signed [SAMPLE_W-1:0] samp_q;
  logic [COLUMN_W-1:0]        col_q;
  logic                       cs_q;
  logic [63:0]                sm_q, z_q, p_q, e_q;
  logic [1:0]                 ph_q;
  logic                       second_q;
  logic [2:0]                 mix_idx_q;
  logic [LW-1:0]              pos_q;
  logic [ACC_W-1:0]           acc_q;
  logic signed [WEIGHT_W-1:0] w_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [ACC_W-1:0]           num_q;
  logic [6:0]                 rem_q;
  logic                       neg_q;
  logic [5:0]                 div_cnt_q;
  logic                       div_ph_q;
  logic [46:0]                dprod_q;
  logic                       out_valid_q, out_valid_d;
  logic [DOT_W-1:0]           dot_q;

  logic [LW-1:0]    rl_ext, k_len, full_len, pos_next;
  logic             need_draw, row_end, out_free;
  logic [63:0]      seed_w, sm_add, mz, mix_out;
  logic [63:0]      mc;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;
  logic [22:0]      div_x, div_qm;
  logic [15:0]      div_q;
  logic [6:0]       div_r;
  logic [ACC_W-1:0] acc_new;
  logic [DOT_W-1:0] dot_w;

  // row length clamp and element classification
  always_comb begin
    rl_ext = LW'(cfg_i.row_length);
    if (rl_ext == '0) begin
      k_len = LW'(1);
    end else if (rl_ext > KMAX) begin
      k_len = KMAX;
    end else begin
      k_len = rl_ext;
    end
    full_len  = {k_len[LW-1:2], 2'b00};
    need_draw = (pos_q >= full_len) || (pos_q[1:0] == 2'b00);
    pos_next  = pos_q + LW'(1);
    row_end   = (pos_next >= k_len);
  end

  // xorshift128+ step, all lanes side by side
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [63:0] x1;
    assign x1        = lane_a_q[g] ^ (lane_a_q[g] << 23);
    assign nb_w[g]   = x1 ^ lane_b_q[g] ^ (x1 >> 17) ^ (lane_b_q[g] >> 26);
    assign draw_w[g] = nb_w[g] + lane_b_q[g];
  end

  // column seed and the shared 32x32 multiplier
  always_comb begin
    seed_w  = cfg_i.root_seed
            ^ ({48'd0, cfg_i.layer_number} * {32'd0, LAYER_MUL})
            ^ ({48'd0, col_q} * {32'd0, COLUMN_MUL});
    sm_add  = sm_q + GOLDEN;
    mc      = second_q ? MIX_C2 : MIX_C1;
    mul_a   = (ph_q == 2'd1) ? z_q[63:32] : z_q[31:0];
    mul_b   = (ph_q == 2'd2) ? mc[63:32] : mc[31:0];
    mul_p   = mul_a * mul_b;
    mz      = p_q ^ (p_q >> 27);
    mix_out = p_q ^ (p_q >> 31);
    acc_new = acc_q + ACC_W'(prod_q);
  end

  // divide by 81 one 16-bit digit at a time
  always_comb begin
    div_x  = {rem_q, num_q[ACC_W-1 -: 16]};
    div_q  = dprod_q[RECIP_SHIFT +: 16];
    div_qm = {7'd0, div_q} * {15'd0, DIVISOR};
    div_r  = 7'(div_x - div_qm);
  end

  // rounded quotient back to the signed dot range
  always_comb begin
    if (neg_q) begin
      if (num_q > (ACC_W'(1) << (DOT_W - 1))) begin
        dot_w = {1'b1, {(DOT_W-1){1'b0}}};
      end else begin
        dot_w = DOT_W'(-num_q[DOT_W-1:0]);
      end
    end else if (num_q > ((ACC_W'(1) << (DOT_W - 1)) - ACC_W'(1))) begin
      dot_w = {1'b0, {(DOT_W-1){1'b1}}};
    end else begin
      dot_w = num_q[DOT_W-1:0];
    end
  end

  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.column_start ? ST_SEED : ST_DRAW;
        end
      end
      ST_SEED: state_d = ST_MIX;
      ST_MIX:  state_d = ST_MUL;
      ST_MUL: begin
        if (ph_q == 2'd2) begin
          state_d = ST_MULX;
        end
      end
      ST_MULX: begin
        if (!second_q) begin
          state_d = ST_MUL;
        end else if (mix_idx_q == 3'd7) begin
          state_d = ST_DRAW;
        end else begin
          state_d = ST_MIX;
        end
      end
      ST_DRAW: state_d = ST_WT;
      ST_WT:   state_d = ST_MAC;
      ST_MAC:  state_d = ST_ACC;
      ST_ACC:  state_d = row_end ? ST_DIVI : ST_IDLE;
      ST_DIVI: state_d = ST_DIV;
      ST_DIV: begin
        if (div_ph_q && (div_cnt_q == 6'd0)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_pop_o = (state_q == ST_IDLE) && item_valid_i;
    empty_o    = !out_valid_q;
    dot_o      = $signed(dot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      acc_q       <= '0;
      ph_q        <= 2'd0;
      second_q    <= 1'b0;
      mix_idx_q   <= 3'd0;
      div_cnt_q   <= 6'd0;
      div_ph_q    <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        lane_a_q[i] <= '0;
        lane_b_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_SEED: begin
          mix_idx_q <= 3'd0;
          pos_q     <= '0;
          acc_q     <= '0;
        end
        ST_MIX: begin
          ph_q     <= 2'd0;
          second_q <= 1'b0;
        end
        ST_MUL: begin
          ph_q <= (ph_q == 2'd2) ? 2'd0 : 2'(ph_q + 2'd1);
        end
        ST_MULX: begin
          if (!second_q) begin
            second_q <= 1'b1;
          end else begin
            if (mix_idx_q[2]) begin
              lane_b_q[mix_idx_q[1:0]] <= mix_out;
            end else begin
              lane_a_q[mix_idx_q[1:0]] <= mix_out;
            end
            mix_idx_q <= 3'(mix_idx_q + 3'd1);
          end
        end
        ST_DRAW: begin
          if (need_draw) begin
            for (int i = 0; i < LANES; i++) begin
              lane_a_q[i] <= lane_b_q[i];
              lane_b_q[i] <= nb_w[i];
            end
          end
        end
        ST_ACC: begin
          acc_q <= acc_new;
          pos_q <= pos_next;
        end
        ST_DIVI: begin
          pos_q     <= '0;
          acc_q     <= '0;
          div_cnt_q <= 6'd2;
          div_ph_q  <= 1'b0;
        end
        ST_DIV: begin
          div_ph_q <= !div_ph_q;
          if (div_ph_q) begin
            div_cnt_q <= 6'(div_cnt_q - 6'd1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath words, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          samp_q <= item_i.sample;
          col_q  <= item_i.column;
          cs_q   <= item_i.column_start;
        end
      end
      ST_SEED: sm_q <= seed_w;
      ST_MIX: begin
        sm_q <= sm_add;
        z_q  <= sm_add ^ (sm_add >> 30);
      end
      ST_MUL: begin
        if (ph_q == 2'd0) begin
          p_q <= mul_p;
        end else begin
          p_q <= p_q + {mul_p[31:0], 32'h0};
        end
      end
      ST_MULX: begin
        if (!second_q) begin
          z_q <= mz;
        end
      end
      ST_DRAW: begin
        if (need_draw) begin
          for (int i = 0; i < LANES; i++) begin
            buf_q[i] <= draw_w[i];
          end
          e_q <= draw_w[0];
        end else begin
          e_q <= buf_q[pos_q[1:0]];
        end
      end
      ST_WT:  w_q <= weight81(e_q);
      ST_MAC: prod_q <= samp_q * w_q;
      ST_DIVI: begin
        neg_q <= acc_q[ACC_W-1];
        num_q <= (acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q) + ROUND_BIAS;
        rem_q <= 7'd0;
      end
      ST_DIV: begin
        if (!div_ph_q) begin
          dprod_q <= {24'd0, div_x} * {23'd0, RECIP81};
        end else begin
          rem_q <= div_r;
          num_q <= {num_q[ACC_W-17:0], div_q};
        end
      end
      ST_OUT: begin
        if (out_free) begin
          dot_q <= dot_w;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_ph_q && div_cnt_q == 6'd0) |=> (state_q == ST_OUT))
    else $error("divider did not finish");
  a_word_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result word appeared outside output state");
  a_seed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULX && second_q && mix_idx_q == 3'd7) |=> (state_q == ST_DRAW))
    else $error("reseed did not hand over to draw");
  a_seed_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> cs_q)
    else $error("reseed without column start");
`endif

endmodule

// File: design/generated_weight_dot_product.sv
// generated weight dot product
// input: push_i with sample_i, column_i and column_start_i; a word is taken
// when push_i is high and full_o is low. a two-word queue sits in front.
// results: dot_o is valid while empty_o is low and leaves on pop_i.
// configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 base seed, 1 layer number, 2 row length. ready is always high.
// per sample: the word is taken, then the draw, weight, multiply and accumulate
// steps follow. a column start first adds splitmix seeding of the eight lane
// words, on one shared 32x32 multiplier in three passes per product.
// a row end adds the divide by 81, three 16-bit digits of a reciprocal
// multiply and a remainder step each, then a step to load the output.
// the result sits in a single output register; while it is not taken the
// engine holds at the next row end and the input queue fills, then full_o rises.
// reset clears the generator lanes, the row position, the accumulator, the
// input queue, the output valid flag and the registers (row length 1).
module generated_weight_dot_product #(
  parameter int unsigned MAX_ROW_LENGTH = gwdp_pkg::DEF_MAX_ROW_LENGTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic signed [gwdp_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [gwdp_pkg::COLUMN_W-1:0]        column_i,
  input  logic                                 column_start_i,
  input  logic                                 pop_i,
  output logic                                 empty_o,
  output logic signed [gwdp_pkg::DOT_W-1:0]    dot_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gwdp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [63:0]                          cfg_data_i
);
  import gwdp_pkg::*;

  cfg_t  cfg_q;
  item_t in_item, q_item;
  logic  q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign in_item     = '{sample: sample_i, column: column_i, column_start: column_start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_seed    <= '0;
      cfg_q.layer_number <= '0;
      cfg_q.row_length   <= ROWLEN_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_SEED:  cfg_q.root_seed    <= cfg_data_i;
        REG_LAYER:      cfg_q.layer_number <= cfg_data_i[15:0];
        REG_ROW_LENGTH: cfg_q.row_length   <= cfg_data_i[ROWLEN_W-1:0];
        default: ;
      endcase
    end
  end

  gwdp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .item_i       (in_item),
    .full_o       (full_o),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .item_pop_i   (q_pop)
  );

  gwdp_back #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .dot_o        (dot_o)
  );

endmodule
